// ----- rtl/core/fepg_pkg.sv -----
// Shared types and constants of the filled ellipse pixel generator.
// Used by the channel interfaces, the register file, controller and datapath.
package fepg_pkg;

    localparam int CENTER_W = 13;   // signed center coordinate
    localparam int RADIUS_W = 11;   // unsigned semi-axis
    localparam int COORD_W  = 14;   // bounding box coordinate, signed
    localparam int SQ_W     = 22;   // square of a radius or offset
    localparam int PROD_W   = 44;   // product of two squares
    localparam int COLOR_W  = 24;
    localparam int ADDR_W   = 32;
    localparam int DIM_W    = 13;   // screen size register
    localparam int BPP_W    = 3;
    localparam int PDATA_W  = 32;
    localparam int PADDR_W  = 4;

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    typedef enum logic [1:0] {
        REG_LINE_PIXELS     = 2'd0,
        REG_LINE_COUNT      = 2'd1,
        REG_BYTES_PER_PIXEL = 2'd2,
        REG_FRAME_BASE      = 2'd3
    } reg_idx_t;

    localparam logic [DIM_W-1:0]  RST_LINE_PIXELS     = 13'd1024;
    localparam logic [DIM_W-1:0]  RST_LINE_COUNT      = 13'd768;
    localparam logic [BPP_W-1:0]  RST_BYTES_PER_PIXEL = 3'd3;
    localparam logic [ADDR_W-1:0] RST_FRAME_BASE      = 32'd0;

    typedef struct packed {
        logic [DIM_W-1:0]  line_pixels;
        logic [DIM_W-1:0]  line_count;
        logic [BPP_W-1:0]  bytes_per_pixel;
        logic [ADDR_W-1:0] frame_base;
    } cfg_t;

    typedef struct packed {
        logic                       kind;
        logic signed [CENTER_W-1:0] center_x;
        logic signed [CENTER_W-1:0] center_y;
        logic [RADIUS_W-1:0]        radius_x;
        logic [RADIUS_W-1:0]        radius_y;
        logic [COLOR_W-1:0]         color;
    } in_item_t;

    typedef struct packed {
        logic               write_valid;
        logic [ADDR_W-1:0]  pixel_address;
        logic [COLOR_W-1:0] pixel_color;
        logic               last;
        logic               idle_tick;
    } out_item_t;

    // Controller to datapath: one strobe per step of the item's work
    typedef struct packed {
        logic capture;
        logic setup;
        logic square;
        logic scale;
        logic load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_full;
    } dp_status_t;

endpackage

// ----- rtl/core/fepg_stream_if.sv -----
// Valid/ready channel interfaces for ellipse commands and pixel writes.
// Depends on fepg_pkg for the field widths.
interface fepg_in_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 kind;
    logic signed [fepg_pkg::CENTER_W-1:0] center_x;
    logic signed [fepg_pkg::CENTER_W-1:0] center_y;
    logic [fepg_pkg::RADIUS_W-1:0]        radius_x;
    logic [fepg_pkg::RADIUS_W-1:0]        radius_y;
    logic [fepg_pkg::COLOR_W-1:0]         color;

    modport source (output valid, kind, center_x, center_y, radius_x, radius_y, color,
                    input ready);
    modport sink (input valid, kind, center_x, center_y, radius_x, radius_y, color,
                  output ready);
endinterface

interface fepg_out_if;
    logic                         valid;
    logic                         ready;
    logic                         write_valid;
    logic [fepg_pkg::ADDR_W-1:0]  pixel_address;
    logic [fepg_pkg::COLOR_W-1:0] pixel_color;
    logic                         last;
    logic                         idle_tick;

    modport source (output valid, write_valid, pixel_address, pixel_color, last, idle_tick,
                    input ready);
    modport sink (input valid, write_valid, pixel_address, pixel_color, last, idle_tick,
                  output ready);
endinterface

// ----- rtl/core/filled_ellipse_pixel_generator.sv -----
// Top level of the filled ellipse pixel generator: register file, step
// controller and datapath. Depends on fepg_pkg and fepg_stream_if.
//
// Usage: a start item (kind 0) on ellipse_in latches the center, radii and
// color and opens the bounding box; each tick item (kind 1) then visits one
// box position, column-major with the row inner. Every item, start or tick,
// produces exactly one item on pixel_out: a frame buffer write when
// write_valid is set, last on the final box position, idle_tick for a tick
// with no ellipse open. Screen size, pixel stride and frame base sit on the
// APB port; the user must write them while the block is idle (not enforced).
// Each item runs through the setup, square, scale and done states, and a new
// item waits until the current one has had its four steps (offset and
// clip, squaring, scaling by the radii, sum and compare).
// The next item is accepted in the cycle the result enters the output
// register, so a waiting result does not block intake while that register
// is free or being drained. When pixel_out stalls with a result pending, the
// block finishes the current item and holds it until the register frees.
// Reset clears the configuration to 1024x768, 3 bytes per pixel, base 0,
// closes any ellipse and empties the output register.
module filled_ellipse_pixel_generator #(
    parameter int MAX_SCREEN_DIM = 4096
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fepg_pkg::PADDR_W-1:0]  paddr,
    input  logic [fepg_pkg::PDATA_W-1:0]  pwdata,
    output logic [fepg_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    fepg_in_if.sink                       ellipse_in,
    fepg_out_if.source                    pixel_out
);

    fepg_pkg::cfg_t       cfg;
    fepg_pkg::ctrl_cmd_t  cmd;
    fepg_pkg::dp_status_t status;
    fepg_pkg::in_item_t   in_item;
    fepg_pkg::out_item_t  out_item;
    logic                 in_ready;

    fepg_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fepg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ellipse_in.valid),
        .out_ready (pixel_out.ready),
        .status    (status),
        .in_ready  (in_ready),
        .cmd       (cmd)
    );

    assign in_item.kind     = ellipse_in.kind;
    assign in_item.center_x = ellipse_in.center_x;
    assign in_item.center_y = ellipse_in.center_y;
    assign in_item.radius_x = ellipse_in.radius_x;
    assign in_item.radius_y = ellipse_in.radius_y;
    assign in_item.color    = ellipse_in.color;

    fepg_datapath #(
        .MAX_SCREEN_DIM (MAX_SCREEN_DIM)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cfg       (cfg),
        .in_item   (in_item),
        .out_ready (pixel_out.ready),
        .out_item  (out_item),
        .status    (status)
    );

    assign ellipse_in.ready        = in_ready;
    assign pixel_out.valid         = status.out_full;
    assign pixel_out.write_valid   = out_item.write_valid;
    assign pixel_out.pixel_address = out_item.pixel_address;
    assign pixel_out.pixel_color   = out_item.pixel_color;
    assign pixel_out.last          = out_item.last;
    assign pixel_out.idle_tick     = out_item.idle_tick;

    // One item in flight: no intake in the cycle after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (ellipse_in.valid && ellipse_in.ready) |=> !ellipse_in.ready)
        else $error("item accepted while previous item still in setup");

    // A write never comes from a tick that found no ellipse open
    a_write_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_out.valid |-> !(pixel_out.write_valid && pixel_out.idle_tick))
        else $error("write flagged on an idle tick");

    // Non-writes carry a zero address and color
    a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (pixel_out.valid && !pixel_out.write_valid)
            |-> (pixel_out.pixel_address == '0 && pixel_out.pixel_color == '0))
        else $error("non-write item carries address or color");

    // The output register fills only on the controller's load step
    a_fill_on_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pixel_out.valid) |-> $past(cmd.load))
        else $error("result appeared without a load step");

endmodule

// ----- rtl/core/fepg_cfg_regs.sv -----
// APB-style configuration registers: screen size, pixel stride, frame base.
// Depends on fepg_pkg.
module fepg_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [fepg_pkg::PADDR_W-1:0]   paddr,
    input  logic [fepg_pkg::PDATA_W-1:0]   pwdata,
    output logic [fepg_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready,
    output fepg_pkg::cfg_t                 cfg
);

    fepg_pkg::cfg_t     cfg_reg;
    fepg_pkg::reg_idx_t idx;
    logic               wr_en;

    assign idx    = fepg_pkg::reg_idx_t'(paddr[fepg_pkg::PADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.line_pixels     <= fepg_pkg::RST_LINE_PIXELS;
            cfg_reg.line_count      <= fepg_pkg::RST_LINE_COUNT;
            cfg_reg.bytes_per_pixel <= fepg_pkg::RST_BYTES_PER_PIXEL;
            cfg_reg.frame_base      <= fepg_pkg::RST_FRAME_BASE;
        end
        else if (wr_en)
        begin
            unique case (idx)
                fepg_pkg::REG_LINE_PIXELS:
                    cfg_reg.line_pixels <= pwdata[fepg_pkg::DIM_W-1:0];
                fepg_pkg::REG_LINE_COUNT:
                    cfg_reg.line_count <= pwdata[fepg_pkg::DIM_W-1:0];
                fepg_pkg::REG_BYTES_PER_PIXEL:
                    cfg_reg.bytes_per_pixel <= pwdata[fepg_pkg::BPP_W-1:0];
                fepg_pkg::REG_FRAME_BASE:
                    cfg_reg.frame_base <= pwdata[fepg_pkg::ADDR_W-1:0];
                default:
                    cfg_reg.frame_base <= cfg_reg.frame_base;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (idx)
            fepg_pkg::REG_LINE_PIXELS:
                prdata = fepg_pkg::PDATA_W'(cfg_reg.line_pixels);
            fepg_pkg::REG_LINE_COUNT:
                prdata = fepg_pkg::PDATA_W'(cfg_reg.line_count);
            fepg_pkg::REG_BYTES_PER_PIXEL:
                prdata = fepg_pkg::PDATA_W'(cfg_reg.bytes_per_pixel);
            fepg_pkg::REG_FRAME_BASE:
                prdata = fepg_pkg::PDATA_W'(cfg_reg.frame_base);
            default:
                prdata = '0;
        endcase
    end

endmodule

// ----- rtl/core/fepg_ctrl.sv -----
// Step sequencer: accepts one item, walks it through four datapath steps
// and hands the result to the output register. Depends on fepg_pkg.
module fepg_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   out_ready,
    input  fepg_pkg::dp_status_t   status,
    output logic                   in_ready,
    output fepg_pkg::ctrl_cmd_t    cmd
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SETUP = 5'b00010,
        ST_SQ    = 5'b00100,
        ST_SCALE = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   can_load;
    logic   load;
    logic   accept;

    // Output register is free when empty or being drained this cycle
    assign can_load = !status.out_full || out_ready;
    assign load     = (state_reg == ST_DONE) && can_load;
    assign in_ready = (state_reg == ST_IDLE) || load;
    assign accept   = in_valid && in_ready;

    assign cmd.capture = accept;
    assign cmd.setup   = (state_reg == ST_SETUP);
    assign cmd.square  = (state_reg == ST_SQ);
    assign cmd.scale   = (state_reg == ST_SCALE);
    assign cmd.load    = load;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_valid)
                    state_next = ST_SETUP;
            ST_SETUP:
                state_next = ST_SQ;
            ST_SQ:
                state_next = ST_SCALE;
            ST_SCALE:
                state_next = ST_DONE;
            ST_DONE:
                if (can_load)
                    state_next = in_valid ? ST_SETUP : ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ----- rtl/core/fepg_datapath.sv -----
// Ellipse state, scan counters, inside test, address arithmetic and the
// output register. Steps are strobed by fepg_ctrl. Depends on fepg_pkg.
module fepg_datapath #(
    parameter int MAX_SCREEN_DIM = 4096
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  fepg_pkg::ctrl_cmd_t    cmd,
    input  fepg_pkg::cfg_t         cfg,
    input  fepg_pkg::in_item_t     in_item,
    input  logic                   out_ready,
    output fepg_pkg::out_item_t    out_item,
    output fepg_pkg::dp_status_t   status
);

    localparam int SAT_W = $clog2(MAX_SCREEN_DIM + 1);
    localparam int WW    = (SAT_W > fepg_pkg::DIM_W) ? SAT_W : fepg_pkg::DIM_W;
    localparam int YW_W  = fepg_pkg::DIM_W + WW;
    localparam int CW    = fepg_pkg::COORD_W;
    localparam int RW    = fepg_pkg::RADIUS_W;
    localparam int SW    = fepg_pkg::SQ_W;
    localparam int PW    = fepg_pkg::PROD_W;
    localparam int AW    = fepg_pkg::ADDR_W;
    localparam int OW    = AW + fepg_pkg::BPP_W;

    // Held item
    fepg_pkg::in_item_t in_reg;

    // Ellipse state
    logic                 busy_reg;
    logic signed [CW-1:0] scan_col_reg;
    logic signed [CW-1:0] scan_row_reg;
    logic signed [CW-1:0] col_end_reg;
    logic signed [CW-1:0] row_first_reg;
    logic signed [CW-1:0] row_end_reg;
    logic signed [CW-1:0] held_cx_reg;
    logic signed [CW-1:0] held_cy_reg;
    logic [SW-1:0]        rx_sq_reg;
    logic [SW-1:0]        ry_sq_reg;
    logic [PW-1:0]        rp_sq_reg;
    logic [fepg_pkg::COLOR_W-1:0] fill_color_reg;

    // Per-position pipeline
    logic [RW-1:0]                adx_reg;
    logic [RW-1:0]                ady_reg;
    logic [fepg_pkg::DIM_W-1:0]   x_reg;
    logic [YW_W-1:0]              yw_reg;
    logic                         visible_reg;
    logic                         last_reg;
    logic                         idle_reg;
    logic [SW-1:0]                adx_sq_reg;
    logic [SW-1:0]                ady_sq_reg;
    logic [AW-1:0]                idx_reg;
    logic [PW-1:0]                term_x_reg;
    logic [PW-1:0]                term_y_reg;
    logic [AW-1:0]                offset_reg;

    // Output register
    fepg_pkg::out_item_t out_reg;
    logic                out_full_reg;

    logic [WW-1:0]        width_sat;
    logic [WW-1:0]        height_sat;
    logic signed [CW-1:0] cx_ext;
    logic signed [CW-1:0] cy_ext;
    logic signed [CW-1:0] rx_ext;
    logic signed [CW-1:0] ry_ext;
    logic                 radii_nonzero;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [CW-1:0] ndx;
    logic signed [CW-1:0] ndy;
    logic                 on_screen;
    logic signed [CW-1:0] row_inc;
    logic signed [CW-1:0] col_inc;
    logic                 row_wrap;
    logic                 col_wrap;
    logic [YW_W-1:0]      yw_next;
    logic [OW-1:0]        offset_full;
    logic [PW:0]          lhs;
    logic                 in_ellipse;
    logic                 hit;

    always_comb
    begin
        width_sat  = (WW'(cfg.line_pixels) > WW'(MAX_SCREEN_DIM))
                   ? WW'(MAX_SCREEN_DIM) : WW'(cfg.line_pixels);
        height_sat = (WW'(cfg.line_count) > WW'(MAX_SCREEN_DIM))
                   ? WW'(MAX_SCREEN_DIM) : WW'(cfg.line_count);
    end

    assign cx_ext        = CW'(in_reg.center_x);
    assign cy_ext        = CW'(in_reg.center_y);
    assign rx_ext        = $signed(CW'(in_reg.radius_x));
    assign ry_ext        = $signed(CW'(in_reg.radius_y));
    assign radii_nonzero = (in_reg.radius_x != '0) && (in_reg.radius_y != '0);

    // Offsets from the center stay within one radius inside the box
    assign dx  = scan_col_reg - held_cx_reg;
    assign dy  = scan_row_reg - held_cy_reg;
    assign ndx = -dx;
    assign ndy = -dy;

    assign on_screen = !scan_col_reg[CW-1] && !scan_row_reg[CW-1]
                    && (WW'(scan_col_reg[fepg_pkg::DIM_W-1:0]) < width_sat)
                    && (WW'(scan_row_reg[fepg_pkg::DIM_W-1:0]) < height_sat);

    assign row_inc  = scan_row_reg + CW'(1);
    assign col_inc  = scan_col_reg + CW'(1);
    assign row_wrap = (row_inc >= row_end_reg);
    assign col_wrap = (col_inc >= col_end_reg);

    assign yw_next     = YW_W'(scan_row_reg[fepg_pkg::DIM_W-1:0]) * YW_W'(width_sat);
    assign offset_full = OW'(idx_reg) * OW'(cfg.bytes_per_pixel);

    assign lhs        = {1'b0, term_x_reg} + {1'b0, term_y_reg};
    assign in_ellipse = (lhs <= {1'b0, rp_sq_reg});
    assign hit        = visible_reg && in_ellipse;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            in_reg <= in_item;
    end

    // Setup step: open a new box, or test and advance the scan position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else if (cmd.setup)
        begin
            if (in_reg.kind == fepg_pkg::KIND_START)
                busy_reg <= radii_nonzero;
            else if (busy_reg && row_wrap && col_wrap)
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.setup)
        begin
            adx_reg     <= dx[CW-1] ? ndx[RW-1:0] : dx[RW-1:0];
            ady_reg     <= dy[CW-1] ? ndy[RW-1:0] : dy[RW-1:0];
            x_reg       <= scan_col_reg[fepg_pkg::DIM_W-1:0];
            yw_reg      <= yw_next;
            visible_reg <= (in_reg.kind == fepg_pkg::KIND_TICK) && busy_reg && on_screen;
            idle_reg    <= (in_reg.kind == fepg_pkg::KIND_TICK) && !busy_reg;
            if (in_reg.kind == fepg_pkg::KIND_START)
            begin
                held_cx_reg    <= cx_ext;
                held_cy_reg    <= cy_ext;
                scan_col_reg   <= cx_ext - rx_ext;
                col_end_reg    <= cx_ext + rx_ext;
                row_first_reg  <= cy_ext - ry_ext;
                scan_row_reg   <= cy_ext - ry_ext;
                row_end_reg    <= cy_ext + ry_ext;
                rx_sq_reg      <= SW'(in_reg.radius_x) * SW'(in_reg.radius_x);
                ry_sq_reg      <= SW'(in_reg.radius_y) * SW'(in_reg.radius_y);
                fill_color_reg <= in_reg.color;
                last_reg       <= !radii_nonzero;
            end
            else if (busy_reg)
            begin
                last_reg <= row_wrap && col_wrap;
                if (row_wrap)
                begin
                    scan_row_reg <= row_first_reg;
                    scan_col_reg <= col_inc;
                end
                else
                    scan_row_reg <= row_inc;
            end
            else
                last_reg <= 1'b0;
        end

        if (cmd.square)
        begin
            if (in_reg.kind == fepg_pkg::KIND_START)
                rp_sq_reg <= PW'(rx_sq_reg) * PW'(ry_sq_reg);
            adx_sq_reg <= SW'(adx_reg) * SW'(adx_reg);
            ady_sq_reg <= SW'(ady_reg) * SW'(ady_reg);
            idx_reg    <= AW'(x_reg) + AW'(yw_reg);
        end

        if (cmd.scale)
        begin
            term_x_reg <= PW'(adx_sq_reg) * PW'(ry_sq_reg);
            term_y_reg <= PW'(ady_sq_reg) * PW'(rx_sq_reg);
            offset_reg <= offset_full[AW-1:0];
        end

        if (cmd.load)
        begin
            out_reg.write_valid   <= hit;
            out_reg.pixel_address <= hit ? (cfg.frame_base + offset_reg) : '0;
            out_reg.pixel_color   <= hit ? fill_color_reg : '0;
            out_reg.last          <= last_reg;
            out_reg.idle_tick     <= idle_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_full_reg <= 1'b0;
        else if (cmd.load)
            out_full_reg <= 1'b1;
        else if (out_ready)
            out_full_reg <= 1'b0;
    end

    assign out_item        = out_reg;
    assign status.out_full = out_full_reg;

endmodule
